[sv/vrl_pkg.sv]
// Shared types and constants for the velocity ramp limiter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package vrl_pkg;

    // Field widths
    localparam int VEL_W  = 32;   // Q16.16 velocity and displacement
    localparam int CFG_W  = 31;   // unsigned Q15.16 rates and limit
    localparam int DIR_W  = 16;   // signed Q2.14 direction
    localparam int TIME_W = 16;   // unsigned Q0.16 frame time

    // Saturation limits of a velocity
    localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

    // Operation codes (the fourth code leaves the velocity unchanged)
    typedef enum logic [1:0] {
        OP_ACCEL = 2'd0,
        OP_TICK  = 2'd1,
        OP_LOAD  = 2'd2
    } t_op;

    // Sequencer strobes shared by both axis lanes
    typedef struct packed {
        t_op  op;
        logic st1;   // products of time, clamp
        logic st2;   // acceleration product, friction
        logic st3;   // velocity update, displacement
    } t_lane_ctl;

endpackage

`default_nettype wire

[sv/vrl_lane.sv]
// One axis lane: velocity register plus accelerate, tick and load datapath.
// Depends on vrl_pkg; instantiated twice by velocity_ramp_limiter_unit.
`timescale 1ns / 1ps
`default_nettype none

module vrl_lane
    import vrl_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire t_lane_ctl          i_ctl,
    input  wire signed [DIR_W-1:0]  i_dir,
    input  wire [TIME_W-1:0]        i_time,
    input  wire signed [VEL_W-1:0]  i_set_value,
    input  wire                     i_set_enable,
    input  wire [CFG_W-1:0]         i_max_speed,
    input  wire [CFG_W-1:0]         i_accel_rate,
    input  wire [CFG_W-1:0]         i_decel_rate,
    output logic [VEL_W-1:0]        o_velocity,
    output logic [VEL_W-1:0]        o_displacement
);

    localparam int DT_W   = DIR_W + TIME_W - 1;   // |dir| * t stays below 2^31
    localparam int ACC_W  = CFG_W + DT_W;
    localparam int DECP_W = CFG_W + TIME_W;
    localparam int DISP_W = VEL_W + TIME_W;
    localparam int WIDE_W = VEL_W + 2;

    logic [VEL_W-1:0]   r_vel;
    logic [VEL_W-1:0]   r_work;
    logic [DT_W-1:0]    r_dt;
    logic [CFG_W-1:0]   r_dec;
    logic [ACC_W-1:0]   r_acc;
    logic               r_dir_neg;
    logic [VEL_W-1:0]   r_disp;

    logic [DIR_W-1:0]        w_dir_mag;
    logic [DIR_W+TIME_W-1:0] w_dt_full;
    logic [DECP_W-1:0]       w_dec_full;
    logic signed [VEL_W:0]   w_lim;
    logic signed [VEL_W:0]   w_v33;
    logic signed [VEL_W:0]   w_w33;
    logic signed [VEL_W:0]   w_dec33;
    logic [VEL_W-1:0]        n_clamp;
    logic [VEL_W-1:0]        n_fric;
    logic signed [WIDE_W-1:0] w_delta;
    logic signed [WIDE_W-1:0] w_sum;
    logic [VEL_W-1:0]        n_accel;
    logic [VEL_W-1:0]        w_work_mag;
    logic [DISP_W-1:0]       w_disp_prod;
    logic [VEL_W-1:0]        w_disp_mag;
    logic [VEL_W-1:0]        n_disp;
    logic [VEL_W-1:0]        n_vel;

    // Stage 1: direction magnitude times time, friction step, speed clamp
    always_comb begin
        w_dir_mag  = i_dir[DIR_W-1] ? DIR_W'(-i_dir) : DIR_W'(i_dir);
        w_dt_full  = {{TIME_W{1'b0}}, w_dir_mag} * {{DIR_W{1'b0}}, i_time};
        w_dec_full = {{TIME_W{1'b0}}, i_decel_rate} * {{CFG_W{1'b0}}, i_time};
        w_lim      = {2'b00, i_max_speed};
        w_v33      = {r_vel[VEL_W-1], r_vel};
        if (w_v33 > w_lim) begin
            n_clamp = w_lim[VEL_W-1:0];
        end else if (w_v33 < -w_lim) begin
            n_clamp = VEL_W'(-w_lim);
        end else begin
            n_clamp = r_vel;
        end
    end

    // Stage 2: move toward zero without crossing it
    always_comb begin
        w_w33   = {r_work[VEL_W-1], r_work};
        w_dec33 = {2'b00, r_dec};
        if (w_w33 > 0) begin
            n_fric = (w_w33 > w_dec33) ? VEL_W'(w_w33 - w_dec33) : '0;
        end else if (w_w33 < 0) begin
            n_fric = (w_w33 < -w_dec33) ? VEL_W'(w_w33 + w_dec33) : '0;
        end else begin
            n_fric = r_work;
        end
    end

    // Stage 3: saturating add of the acceleration step
    always_comb begin
        w_delta = {2'b00, r_acc[ACC_W-1:30]};
        if (r_dir_neg) begin
            w_delta = -w_delta;
        end
        w_sum = {{2{r_vel[VEL_W-1]}}, r_vel} + w_delta;
        if (w_sum[WIDE_W-1:VEL_W-1] != {3{w_sum[VEL_W-1]}}) begin
            n_accel = w_sum[WIDE_W-1] ? VEL_MIN : VEL_MAX;
        end else begin
            n_accel = w_sum[VEL_W-1:0];
        end
    end

    // Stage 3: displacement from the updated velocity, truncated toward zero
    always_comb begin
        w_work_mag  = r_work[VEL_W-1] ? VEL_W'(-r_work) : r_work;
        w_disp_prod = {{TIME_W{1'b0}}, w_work_mag} * {{VEL_W{1'b0}}, i_time};
        w_disp_mag  = w_disp_prod[DISP_W-1:TIME_W];
        n_disp      = r_work[VEL_W-1] ? VEL_W'(-w_disp_mag) : w_disp_mag;
    end

    // Stage 3: choose next velocity by operation
    always_comb begin
        n_vel = r_vel;
        unique case (i_ctl.op)
            OP_ACCEL: n_vel = n_accel;
            OP_TICK:  n_vel = r_work;
            OP_LOAD:  n_vel = i_set_enable ? i_set_value : r_vel;
            default:  n_vel = r_vel;
        endcase
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.st1) begin
            r_dt      <= w_dt_full[DT_W-1:0];
            r_dec     <= w_dec_full[DECP_W-1:TIME_W];
            r_dir_neg <= i_dir[DIR_W-1];
            r_work    <= n_clamp;
        end
        if (i_ctl.st2) begin
            r_acc  <= {{DT_W{1'b0}}, i_accel_rate} * {{CFG_W{1'b0}}, r_dt};
            r_work <= n_fric;
        end
        if (i_ctl.st3) begin
            r_disp <= (i_ctl.op == OP_TICK) ? n_disp : '0;
        end
    end

    // Velocity state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel <= '0;
        end else if (i_ctl.st3) begin
            r_vel <= n_vel;
        end
    end

    assign o_velocity     = r_vel;
    assign o_displacement = r_disp;

    // Velocity changes only on the update stage
    a_vel_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.st3 |=> $stable(r_vel))
        else $error("lane velocity changed outside update stage");

    // A tick never raises a positive velocity nor lets it turn negative
    a_tick_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.st3 && i_ctl.op == OP_TICK && !r_vel[VEL_W-1])
        |=> (!r_vel[VEL_W-1] && r_vel <= $past(r_vel)))
        else $error("tick increased a positive velocity");

endmodule

`default_nettype wire

[sv/vrl_merge.sv]
// Merge stage: joins both lanes, derives motion flags, holds the result register.
// Depends on vrl_pkg; instantiated by velocity_ramp_limiter_unit.
`timescale 1ns / 1ps
`default_nettype none

module vrl_merge
    import vrl_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_capture,
    input  wire [VEL_W-1:0]     i_vel_x,
    input  wire [VEL_W-1:0]     i_vel_y,
    input  wire [VEL_W-1:0]     i_disp_x,
    input  wire [VEL_W-1:0]     i_disp_y,
    input  wire                 i_ready,
    output logic                o_valid,
    output logic [135:0]        o_data
);

    logic       r_valid;
    logic [135:0] r_data;
    logic [4:0] w_flags;

    // Motion flags: down, up, right, left, moving (high to low)
    always_comb begin
        w_flags[0] = (|i_vel_x) || (|i_vel_y);
        w_flags[1] = i_vel_x[VEL_W-1];
        w_flags[2] = !i_vel_x[VEL_W-1] && (|i_vel_x);
        w_flags[3] = i_vel_y[VEL_W-1];
        w_flags[4] = !i_vel_y[VEL_W-1] && (|i_vel_y);
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_capture) begin
            r_data <= {3'b000, w_flags, i_disp_y, i_disp_x, i_vel_y, i_vel_x};
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_capture) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

[sv/velocity_ramp_limiter_unit.sv]
// Top level of the velocity ramp limiter: sequencer, config registers, two lanes.
// Depends on vrl_pkg, vrl_lane and vrl_merge.
//
//  Channel   Dir  Signals                         Contents
//  s_axis    in   tvalid tready tdata[119:0] tuser[1:0]   one request per step
//  m_axis    out  tvalid tready tdata[135:0]      one result per request
//  cfg       in   i_cfg_we i_cfg_index i_cfg_data  max_speed, accel, decel
//
//  A request passes through three lane stages (time products and clamp,
//  31x31 acceleration product and friction, update and displacement) and
//  a write into the result register. The next request is taken in the
//  write state. A stalled result register holds the sequencer in its write
//  state. Reset (synchronous) zeroes both velocities, the config registers
//  and the result valid flag, and returns the sequencer to idle.
`timescale 1ns / 1ps
`default_nettype none

module velocity_ramp_limiter_unit
    import vrl_pkg::*;
(
    input  wire             i_clk,
    input  wire             i_rst_n,
    // Request: dir_x, dir_y, frame_time, set_x_value, set_y_value,
    // set_x_enable, set_y_enable (from bit 0 up), zero pad to 120
    input  wire             s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire [119:0]     s_axis_tdata,
    // op
    input  wire [1:0]       s_axis_tuser,
    // Result: velocity_x, velocity_y, displacement_x, displacement_y, moving,
    // x negative, x positive, y negative, y positive (from bit 0 up), pad
    output logic            m_axis_tvalid,
    input  wire             m_axis_tready,
    output logic [135:0]    m_axis_tdata,
    // Configuration write
    input  wire             i_cfg_we,
    input  wire [1:0]       i_cfg_index,
    input  wire [CFG_W-1:0] i_cfg_data
);

    localparam logic [1:0] CFG_MAX_SPEED  = 2'd0;
    localparam logic [1:0] CFG_ACCEL_RATE = 2'd1;
    localparam logic [1:0] CFG_DECEL_RATE = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_S1   = 5'b00010,
        ST_S2   = 5'b00100,
        ST_S3   = 5'b01000,
        ST_WB   = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_max_speed, r_accel_rate, r_decel_rate;
    t_op                r_op;
    logic [DIR_W-1:0]   r_dir_x, r_dir_y;
    logic [TIME_W-1:0]  r_time;
    logic [VEL_W-1:0]   r_set_x, r_set_y;
    logic               r_en_x, r_en_y;

    logic               w_accept;
    logic               w_out_free;
    logic               w_capture;
    t_lane_ctl          w_ctl;
    logic [VEL_W-1:0]   w_vel_x, w_vel_y, w_disp_x, w_disp_y;

    // Handshake
    assign w_out_free    = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) || ((r_state == ST_WB) && w_out_free);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_capture     = (r_state == ST_WB) && w_out_free;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed  <= '0;
            r_accel_rate <= '0;
            r_decel_rate <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_SPEED:  r_max_speed  <= i_cfg_data;
                CFG_ACCEL_RATE: r_accel_rate <= i_cfg_data;
                CFG_DECEL_RATE: r_decel_rate <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Request payload, held until the next request
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= t_op'(s_axis_tuser);
            r_dir_x <= s_axis_tdata[15:0];
            r_dir_y <= s_axis_tdata[31:16];
            r_time  <= s_axis_tdata[47:32];
            r_set_x <= s_axis_tdata[79:48];
            r_set_y <= s_axis_tdata[111:80];
            r_en_x  <= s_axis_tdata[112];
            r_en_y  <= s_axis_tdata[113];
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: n_state = w_accept ? ST_S1 : ST_IDLE;
            ST_S1:   n_state = ST_S2;
            ST_S2:   n_state = ST_S3;
            ST_S3:   n_state = ST_WB;
            ST_WB: begin
                if (w_accept) begin
                    n_state = ST_S1;
                end else if (w_capture) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Lane strobes
    always_comb begin
        w_ctl.op  = r_op;
        w_ctl.st1 = (r_state == ST_S1);
        w_ctl.st2 = (r_state == ST_S2);
        w_ctl.st3 = (r_state == ST_S3);
    end

    vrl_lane u_lane_x (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_dir          (r_dir_x),
        .i_time         (r_time),
        .i_set_value    (r_set_x),
        .i_set_enable   (r_en_x),
        .i_max_speed    (r_max_speed),
        .i_accel_rate   (r_accel_rate),
        .i_decel_rate   (r_decel_rate),
        .o_velocity     (w_vel_x),
        .o_displacement (w_disp_x)
    );

    vrl_lane u_lane_y (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_dir          (r_dir_y),
        .i_time         (r_time),
        .i_set_value    (r_set_y),
        .i_set_enable   (r_en_y),
        .i_max_speed    (r_max_speed),
        .i_accel_rate   (r_accel_rate),
        .i_decel_rate   (r_decel_rate),
        .o_velocity     (w_vel_y),
        .o_displacement (w_disp_y)
    );

    vrl_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_capture (w_capture),
        .i_vel_x   (w_vel_x),
        .i_vel_y   (w_vel_y),
        .i_disp_x  (w_disp_x),
        .i_disp_y  (w_disp_y),
        .i_ready   (m_axis_tready),
        .o_valid   (m_axis_tvalid),
        .o_data    (m_axis_tdata)
    );

    // An accepted request always starts the lane stages
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_S1))
        else $error("accepted request did not start the lanes");

    // The update stage is always followed by the result write cycle
    a_s3_to_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_S3) |=> (r_state == ST_WB))
        else $error("update stage not followed by write cycle");

    // A result is captured only into a free result register
    a_capture_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_capture |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwritten while waiting");

endmodule

`default_nettype wire
